// ----- rtl/pcrsb_pkg.sv -----
// package for the point cloud to range scan binner
// types, constants and the atan table for the binner rtl files
package pcrsb_pkg;

  localparam int MAX_BINS_DEF = 2048;
  localparam int SEL_W = 11;
  localparam int RNG_W = 24;
  localparam int CFG_W = 23;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND = 3'd5;

  localparam logic [23:0] RANGE_SAT = 24'hFFFFFF;
  localparam logic signed [31:0] PI_Q20 = 32'sd3294199;

  typedef enum logic {CMD_POINT = 1'b0, CMD_READ = 1'b1} cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_DIV, ST_SQRT, ST_LOOKUP, ST_UPDATE, ST_OUT, ST_CLEAR
  } back_state_t;

  // queued work item from the front part
  typedef struct packed {
    cmd_t               cmd;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [47:0]        rsq;
    logic               keep;
    logic [SEL_W-1:0]   sel;
  } work_t;

  function automatic logic signed [31:0] atan_q20(input logic [4:0] i);
    case (i)
      5'd0: atan_q20 = 32'sd823550;
      5'd1: atan_q20 = 32'sd486170;
      5'd2: atan_q20 = 32'sd256879;
      5'd3: atan_q20 = 32'sd130396;
      5'd4: atan_q20 = 32'sd65451;
      5'd5: atan_q20 = 32'sd32757;
      5'd6: atan_q20 = 32'sd16383;
      5'd7: atan_q20 = 32'sd8192;
      5'd8: atan_q20 = 32'sd4096;
      5'd9: atan_q20 = 32'sd2048;
      5'd10: atan_q20 = 32'sd1024;
      5'd11: atan_q20 = 32'sd512;
      5'd12: atan_q20 = 32'sd256;
      5'd13: atan_q20 = 32'sd128;
      5'd14: atan_q20 = 32'sd64;
      5'd15: atan_q20 = 32'sd32;
      5'd16: atan_q20 = 32'sd16;
      5'd17: atan_q20 = 32'sd8;
      5'd18: atan_q20 = 32'sd4;
      5'd19: atan_q20 = 32'sd2;
      default: atan_q20 = 32'sd0;
    endcase
  endfunction

endpackage

// ----- rtl/pcrsb_if.sv -----
// valid/ready channel interfaces for the binner
// depends on pcrsb_pkg
interface pcrsb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic signed [23:0]          pos_x;
  logic signed [23:0]          pos_y;
  logic signed [23:0]          pos_z;
  logic                        point_ok;
  logic [pcrsb_pkg::SEL_W-1:0] bin_select;
  modport source (output valid, command, pos_x, pos_y, pos_z, point_ok, bin_select,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, point_ok, bin_select,
                output ready);
endinterface

interface pcrsb_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] bin_range;
  logic        bin_hit;
  modport source (output valid, bin_range, bin_hit, input ready);
  modport sink (input valid, bin_range, bin_hit, output ready);
endinterface

// ----- rtl/point_cloud_to_range_scan_binner_top.sv -----
// Point cloud to range scan binner. After reset the back unit clears every entry of the
// bin store; the front queue takes two transactions meanwhile, then stalls. A kept point
// holds the back unit through pop, CORDIC, division, square root, lookup and update. A
// point outside the angle window leaves from the division state and one dropped by the
// front checks at the pop. A read passes through pop, lookup and output; its result is
// registered in the output state once the previous result has been taken.
// The back unit's iterative loops set the rate, one item at a time.
// depends on pcrsb_pkg, pcrsb_if, pcrsb_front and pcrsb_back
module point_cloud_to_range_scan_binner_top #(
  parameter int MAX_BINS = pcrsb_pkg::MAX_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pcrsb_in_if.sink                           in_ch,
  pcrsb_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [pcrsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcrsb_pkg::CFG_W-1:0]        cfg_data
);
  import pcrsb_pkg::*;

  logic signed [15:0] low_r, high_r;
  logic [15:0] width_r;
  logic [CFG_W-1:0] near_r, far_r, band_r;
  logic q_valid, q_pop;
  work_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= -16'sd25736;
      high_r <= 16'sd25736;
      width_r <= 16'd36;
      near_r <= '0;
      far_r <= 23'd30000;
      band_r <= 23'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW: low_r <= cfg_data[15:0];
        REG_HIGH: high_r <= cfg_data[15:0];
        REG_WIDTH: width_r <= cfg_data[15:0];
        REG_NEAR: near_r <= cfg_data;
        REG_FAR: far_r <= cfg_data;
        REG_BAND: band_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pcrsb_front u_front (
    .clk, .rst_n, .in_ch, .near_r, .band_r, .q_valid, .q_data, .q_pop
  );

  pcrsb_back #(.MAX_BINS(MAX_BINS)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .low_r, .high_r, .width_r, .far_r, .out_ch
  );
endmodule

// ----- rtl/pcrsb_front.sv -----
// front part: takes transactions, runs the height and near checks, queues work
// depends on pcrsb_pkg and pcrsb_if
module pcrsb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  pcrsb_in_if.sink                          in_ch,
  input  logic [pcrsb_pkg::CFG_W-1:0]       near_r,
  input  logic [pcrsb_pkg::CFG_W-1:0]       band_r,
  output logic                              q_valid,
  output pcrsb_pkg::work_t                  q_data,
  input  logic                              q_pop
);
  import pcrsb_pkg::*;

  // two entry queue
  work_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  work_t      w;
  logic [23:0] az;
  logic [47:0] xx, yy;
  logic [45:0] nn;
  logic        push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    az = in_ch.pos_z[23] ? 24'(-in_ch.pos_z) : in_ch.pos_z;
    xx = 48'($signed(in_ch.pos_x) * $signed(in_ch.pos_x));
    yy = 48'($signed(in_ch.pos_y) * $signed(in_ch.pos_y));
    nn = near_r * near_r;
    w.cmd = cmd_t'(in_ch.command);
    w.x = in_ch.pos_x;
    w.y = in_ch.pos_y;
    w.rsq = xx + yy;
    w.sel = in_ch.bin_select;
    w.keep = in_ch.point_ok && (az <= {1'b0, band_r}) && (w.rsq >= {2'b00, nn});
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];
endmodule

// ----- rtl/pcrsb_back.sv -----
// back part: cordic angle, bin division, isqrt, bin store update and read out
// depends on pcrsb_pkg and pcrsb_if
module pcrsb_back #(
  parameter int MAX_BINS = pcrsb_pkg::MAX_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  pcrsb_pkg::work_t              q_data,
  output logic                          q_pop,
  input  logic signed [15:0]            low_r,
  input  logic signed [15:0]            high_r,
  input  logic [15:0]                   width_r,
  input  logic [pcrsb_pkg::CFG_W-1:0]   far_r,
  pcrsb_out_if.source                   out_ch
);
  import pcrsb_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = 42;

  back_state_t st_r, st_nxt;
  work_t       it_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [31:0]   cz_r;
  logic [4:0]           step_r;
  logic signed [16:0]   ang_r;
  logic [17:0]          dnum_r;
  logic [16:0]          nb_num_r;
  logic [17:0]          idx_q_r, nb_q_r, drem_r, nrem_r;
  logic [47:0]          sv_r;
  logic [23:0]          sr_r;
  logic [AW-1:0]        addr_r;
  logic [AW-1:0]        clr_r;
  logic [24:0]          rd_r;
  logic [24:0]          store [MAX_BINS];
  logic [23:0]          orng_r;
  logic                 ohit_r, ovalid_r;

  logic [15:0] wdt;
  logic [23:0] empty_rng;
  logic [24:0] far_p;
  logic signed [CW-1:0] xs, ys;
  logic signed [31:0] zr;
  logic [17:0] dr_sh;
  logic [23:0] cur;
  logic [47:0] cursq;
  logic [17:0] lastb, idx_c;
  logic        sel_in;
  logic        rd_hit;
  logic        st_we;
  logic [AW-1:0] st_wa;
  logic [24:0] st_wd;

  assign wdt = (width_r == 16'd0) ? 16'd1 : width_r;
  assign far_p = {2'b00, far_r} + 25'd1000;
  assign empty_rng = far_p[24] ? RANGE_SAT : far_p[23:0];
  assign xs = cx_r >>> step_r;
  assign ys = cy_r >>> step_r;
  assign zr = (cz_r + 32'sd64) >>> 7;
  assign dr_sh = {drem_r[16:0], dnum_r[17]};
  assign rd_hit = rd_r[24];
  assign cur = rd_hit ? rd_r[23:0] : empty_rng;
  assign cursq = cur * cur;
  assign sel_in = ({{(32-SEL_W){1'b0}}, it_r.sel} < 32'(MAX_BINS));

  always_comb begin
    if (nb_q_r == 18'd0) lastb = 18'd0;
    else if (nb_q_r > 18'(MAX_BINS)) lastb = 18'(MAX_BINS - 1);
    else lastb = nb_q_r - 18'd1;
    idx_c = (idx_q_r > lastb) ? lastb : idx_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_CLEAR;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    case (st_r)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        if (q_data.cmd == CMD_READ) st_nxt = ST_LOOKUP;
        else if (q_data.keep) st_nxt = ST_CORDIC;
      end
      ST_CORDIC: if (step_r == 5'd20) st_nxt = ST_DIV;
      ST_DIV: begin
        if ((ang_r < 17'(low_r)) || (ang_r > 17'(high_r))) st_nxt = ST_IDLE;
        else if (step_r == 5'd18) st_nxt = ST_SQRT;
      end
      ST_SQRT: if (step_r == 5'd24) st_nxt = ST_LOOKUP;
      ST_LOOKUP: st_nxt = (it_r.cmd == CMD_READ) ? ST_OUT : ST_UPDATE;
      ST_UPDATE: st_nxt = ST_IDLE;
      ST_OUT: if (!ovalid_r) st_nxt = ST_IDLE;
      ST_CLEAR: if (clr_r == AW'(MAX_BINS - 1)) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        it_r <= q_data;
        step_r <= 5'd0;
        addr_r <= AW'(q_data.sel);
        if (q_data.x < 0) begin
          cx_r <= CW'(-q_data.x) <<< 8;
          cy_r <= CW'(-q_data.y) <<< 8;
          cz_r <= (q_data.y >= 0) ? PI_Q20 : -PI_Q20;
        end else begin
          cx_r <= CW'(q_data.x) <<< 8;
          cy_r <= CW'(q_data.y) <<< 8;
          cz_r <= 32'sd0;
        end
      end
      ST_CORDIC: begin
        if (step_r == 5'd20) begin
          ang_r <= (it_r.x == 0 && it_r.y == 0) ? 17'sd0 : 17'(zr);
          dnum_r <= 18'((it_r.x == 0 && it_r.y == 0 ? 17'sd0 : 17'(zr)) - 17'(low_r));
          nb_num_r <= 17'(17'(high_r) - 17'(low_r) + 17'(wdt) - 17'sd1);
          drem_r <= 18'd0;
          nrem_r <= 18'd0;
          step_r <= 5'd0;
        end else begin
          step_r <= step_r + 5'd1;
          if (cy_r > 0) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + atan_q20(step_r);
          end else if (cy_r < 0) begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - atan_q20(step_r);
          end
        end
      end
      ST_DIV: begin
        // restoring division, quotient and bin count in parallel
        if (step_r == 5'd18) begin
          if (high_r <= low_r) nb_q_r <= 18'd1;
          step_r <= 5'd0;
          sv_r <= it_r.rsq;
          sr_r <= 24'd0;
        end else begin
          step_r <= step_r + 5'd1;
          dnum_r <= {dnum_r[16:0], 1'b0};
          if (dr_sh >= {2'b00, wdt}) drem_r <= dr_sh - {2'b00, wdt};
          else drem_r <= dr_sh;
          idx_q_r <= {((step_r == 5'd0) ? 17'd0 : idx_q_r[16:0]),
                      (dr_sh >= {2'b00, wdt})};
          if (step_r == 5'd0) begin
            if ({17'd0, nb_num_r[16]} >= {2'b00, wdt}) begin
              nrem_r <= {17'd0, nb_num_r[16]} - {2'b00, wdt};
              nb_q_r <= 18'd1;
            end else begin
              nrem_r <= {17'd0, nb_num_r[16]};
              nb_q_r <= 18'd0;
            end
            nb_num_r <= {nb_num_r[15:0], 1'b0};
          end else if (step_r < 5'd17) begin
            if ({nrem_r[16:0], nb_num_r[16]} >= {2'b00, wdt}) begin
              nrem_r <= {nrem_r[16:0], nb_num_r[16]} - {2'b00, wdt};
              nb_q_r <= {nb_q_r[16:0], 1'b1};
            end else begin
              nrem_r <= {nrem_r[16:0], nb_num_r[16]};
              nb_q_r <= {nb_q_r[16:0], 1'b0};
            end
            nb_num_r <= {nb_num_r[15:0], 1'b0};
          end
          // dividend is never negative once in window; top bit is zero
        end
      end
      ST_SQRT: begin
        // one result bit per cycle, 24 digits
        if (step_r == 5'd24) begin
          addr_r <= idx_c[AW-1:0];
        end else begin
          step_r <= step_r + 5'd1;
          if ({sv_r[47:0]} >= 48'(({24'd0, sr_r} << (6'd24 - 6'(step_r))) +
              (48'd1 << (6'd46 - 6'({step_r, 1'b0}))))) begin
            sv_r <= sv_r - 48'(({24'd0, sr_r} << (6'd24 - 6'(step_r))) +
                    (48'd1 << (6'd46 - 6'({step_r, 1'b0}))));
            sr_r <= sr_r | (24'd1 << (5'd23 - step_r));
          end
        end
      end
      default: ;
    endcase
  end

  // single store write port: clearing pass, update and clear on read
  always_comb begin
    st_we = 1'b0;
    st_wa = addr_r;
    st_wd = '0;
    case (st_r)
      ST_CLEAR: begin
        st_we = 1'b1;
        st_wa = clr_r;
      end
      ST_UPDATE: begin
        st_we = (cursq > it_r.rsq);
        st_wd = {1'b1, sr_r};
      end
      ST_OUT: st_we = !ovalid_r && sel_in;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_LOOKUP) rd_r <= store[addr_r];
    if (st_we) store[st_wa] <= st_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (st_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      else if (st_r == ST_OUT && !ovalid_r) ovalid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_OUT && !ovalid_r) begin
      ohit_r <= sel_in && rd_hit;
      orng_r <= (sel_in && rd_hit) ? rd_r[23:0] : empty_rng;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.bin_range = orng_r;
  assign out_ch.bin_hit = ohit_r;
endmodule

// ----- rtl/pcrsb_checker.sv -----
// port level checks for the binner, bound to the top level
// depends on pcrsb_if
module pcrsb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_range,
  input logic        out_hit
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range))
    else $error("result dropped while stalled");
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");
  a_hit_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit))
    else $error("hit flag changed while stalled");
endmodule

bind point_cloud_to_range_scan_binner_top pcrsb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_range(out_ch.bin_range), .out_hit(out_ch.bin_hit)
);
